// ===== src/rct_pkg.sv =====
`default_nettype none

package rct_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEAD    = 3'd1,
    PH_NUM     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ARRAY = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // one result word
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        neg;
    logic        last;
  } token_t;

  // configuration register indexes
  localparam logic CFG_LOWERCASE = 1'b0;
  localparam logic CFG_MAX_LEN   = 1'b1;

  // protocol characters
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT    = 8'h20;

  // bytes skipped after a bulk payload
  localparam logic [1:0] TRAILER_BYTES = 2'd2;

endpackage

`default_nettype wire

// ===== src/rct_in_stage.sv =====
`default_nettype none

module rct_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       advance,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // hold the word while it waits for the parser
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

`default_nettype wire

// ===== src/rct_parser.sv =====
`default_nettype none

module rct_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        step_en,
  input  wire logic [7:0]  byte_in,
  output logic             res_valid,
  output rct_pkg::token_t  res
);

  localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  // configuration
  logic        lower_en_r;
  logic [31:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_en_r <= 1'b1;
      max_len_r  <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rct_pkg::CFG_LOWERCASE: lower_en_r <= cfg_data[0];
        rct_pkg::CFG_MAX_LEN:   max_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser state
  rct_pkg::phase_t         phase_r, phase_nxt;
  logic                    is_array_r, is_array_nxt;
  logic [LENGTH_BITS-1:0]  acc_r, acc_nxt;
  logic                    sign_r, sign_nxt;
  logic                    ended_r, ended_nxt;
  logic                    prev_cr_r, prev_cr_nxt;
  logic [LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic [1:0]              tl_r, tl_nxt;

  // byte classes
  logic is_digit, is_ws, hdr_end;
  assign is_digit = (byte_in >= rct_pkg::CHAR_ZERO) && (byte_in <= rct_pkg::CHAR_NINE);
  assign is_ws    = (byte_in == rct_pkg::CHAR_SPACE) ||
                    ((byte_in >= rct_pkg::CHAR_TAB) && (byte_in <= rct_pkg::CHAR_CR));
  assign hdr_end  = (byte_in == rct_pkg::CHAR_LF) && prev_cr_r;

  // acc*10 + digit, saturating at all ones
  logic [LENGTH_BITS+3:0] acc_ext, acc_x10;
  logic [LENGTH_BITS-1:0] acc_digit;
  assign acc_ext   = {4'b0000, acc_r};
  assign acc_x10   = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_BITS{1'b0}}, byte_in[3:0]};
  assign acc_digit = (acc_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0000) ? '1
                                                                     : acc_x10[LENGTH_BITS-1:0];

  // header length checks
  logic [CW-1:0] mag_w, max_w;
  logic          mag_zero, mag_neg, too_long;
  assign mag_w    = CW'(acc_r);
  assign max_w    = CW'(max_len_r);
  assign mag_zero = (acc_r == '0);
  assign mag_neg  = sign_r && !mag_zero;
  assign too_long = mag_w > max_w;

  logic [LENGTH_BITS-1:0] rem_dec;
  assign rem_dec = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

  logic [1:0] tl_dec;
  assign tl_dec = (tl_r != 2'd0) ? tl_r - 2'd1 : tl_r;

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    is_array_nxt = is_array_r;
    acc_nxt      = acc_r;
    sign_nxt     = sign_r;
    ended_nxt    = ended_r;
    prev_cr_nxt  = prev_cr_r;
    rem_nxt      = rem_r;
    tl_nxt       = tl_r;
    unique case (phase_r)
      rct_pkg::PH_LEAD, rct_pkg::PH_NUM: begin
        if (hdr_end) begin
          if (is_array_r || mag_neg || too_long) begin
            phase_nxt = rct_pkg::PH_IDLE;
          end else if (mag_zero) begin
            phase_nxt = rct_pkg::PH_TRAILER;
            tl_nxt    = rct_pkg::TRAILER_BYTES;
          end else begin
            phase_nxt = rct_pkg::PH_PAYLOAD;
            rem_nxt   = acc_r;
          end
        end else begin
          prev_cr_nxt = (byte_in == rct_pkg::CHAR_CR);
          if (phase_r == rct_pkg::PH_LEAD) begin
            if (!is_ws) begin
              phase_nxt = rct_pkg::PH_NUM;
              if (byte_in == rct_pkg::CHAR_MINUS) begin
                sign_nxt = 1'b1;
              end else if (byte_in == rct_pkg::CHAR_PLUS) begin
                sign_nxt = sign_r;
              end else if (is_digit) begin
                acc_nxt = acc_digit;
              end else begin
                ended_nxt = 1'b1;
              end
            end
          end else if (!ended_r && is_digit) begin
            acc_nxt = acc_digit;
          end else begin
            ended_nxt = 1'b1;
          end
        end
      end
      rct_pkg::PH_PAYLOAD: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = rct_pkg::PH_TRAILER;
          tl_nxt    = rct_pkg::TRAILER_BYTES;
        end
      end
      rct_pkg::PH_TRAILER: begin
        tl_nxt = tl_dec;
        if (tl_dec == 2'd0) begin
          phase_nxt = rct_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = rct_pkg::PH_IDLE;
        if (byte_in == rct_pkg::CHAR_STAR || byte_in == rct_pkg::CHAR_DOLLAR) begin
          is_array_nxt = (byte_in == rct_pkg::CHAR_STAR);
          acc_nxt      = '0;
          sign_nxt     = 1'b0;
          ended_nxt    = 1'b0;
          prev_cr_nxt  = 1'b0;
          phase_nxt    = rct_pkg::PH_LEAD;
        end
      end
    endcase
  end

  // result word
  always_comb begin
    res_valid = 1'b0;
    res.kind  = rct_pkg::KIND_ERROR;
    res.value = '0;
    res.neg   = 1'b0;
    res.last  = 1'b0;
    unique case (phase_r)
      rct_pkg::PH_LEAD, rct_pkg::PH_NUM: begin
        if (hdr_end) begin
          res_valid = 1'b1;
          if (is_array_r) begin
            res.kind  = rct_pkg::KIND_ARRAY;
            res.value = (mag_w > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : mag_w[31:0];
            res.neg   = mag_neg;
          end else if (mag_neg || too_long) begin
            res.kind = rct_pkg::KIND_ERROR;
          end else if (mag_zero) begin
            res.kind = rct_pkg::KIND_EMPTY;
          end else begin
            res_valid = 1'b0;
          end
        end
      end
      rct_pkg::PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.kind  = rct_pkg::KIND_BYTE;
        res.value = {24'h0, byte_in};
        if (lower_en_r && byte_in >= rct_pkg::CHAR_UPPER_A &&
            byte_in <= rct_pkg::CHAR_UPPER_Z) begin
          res.value = {24'h0, byte_in | rct_pkg::CASE_BIT};
        end
        res.last = (rem_dec == '0);
      end
      rct_pkg::PH_TRAILER: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = !(byte_in == rct_pkg::CHAR_STAR || byte_in == rct_pkg::CHAR_DOLLAR);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rct_pkg::PH_IDLE;
      is_array_r <= 1'b0;
      acc_r      <= '0;
      sign_r     <= 1'b0;
      ended_r    <= 1'b0;
      prev_cr_r  <= 1'b0;
      rem_r      <= '0;
      tl_r       <= 2'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      is_array_r <= is_array_nxt;
      acc_r      <= acc_nxt;
      sign_r     <= sign_nxt;
      ended_r    <= ended_nxt;
      prev_cr_r  <= prev_cr_nxt;
      rem_r      <= rem_nxt;
      tl_r       <= tl_nxt;
    end
  end

  // payload phase always has bytes left to deliver
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rct_pkg::PH_PAYLOAD |-> rem_r != '0)
    else $error("payload phase with zero bytes remaining");

  // trailer phase always has a byte left to skip
  a_trailer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rct_pkg::PH_TRAILER |-> tl_r != 2'd0)
    else $error("trailer phase with nothing left to skip");

  // the last payload byte moves the parser into the trailer
  a_last_to_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid && res.kind == rct_pkg::KIND_BYTE && res.last
    |=> phase_r == rct_pkg::PH_TRAILER)
    else $error("last payload byte did not enter trailer");

endmodule

`default_nettype wire

// ===== src/rct_out_stage.sv =====
`default_nettype none

module rct_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic             res_valid,
  input  rct_pkg::token_t       res,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rct_pkg::token_t       out_token
);

  logic            valid_r, valid_nxt;
  rct_pkg::token_t token_r;
  logic            load;

  // register is free when empty or being drained this cycle
  assign out_free = !valid_r || !out_stall;
  assign load     = step_en && res_valid;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_token = token_r;

endmodule

`default_nettype wire

// ===== src/resp_command_tokenizer_top.sv =====
// Byte-serial tokenizer for request headers and bulk strings.
// Input channel: in_valid / in_stall with one stream byte per word on in_byte_in.
// Output channel: out_valid / out_stall with one token per word: kind, value,
// count sign and last-byte mark. Header bytes, trailer bytes and the type byte
// of a good header give no token; a header end gives at most one.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// lowercase enable (0) or maximum bulk length (1), cfg_data is the value.
// Write config only while no bytes are in flight.
// Each accepted byte waits in the input register; the parser decodes it and
// loads any token it gives into the output register once that register is free.
// Throughput: one byte per clock while the output is not stalled; the parser
// state update is combinational (one add of acc*10 plus a compare) so bytes
// stream back to back.
// A stalled output holds its word; the stall reaches in_stall in the same
// cycle once the input register is full.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to waiting for a type byte, sets lowercase on and the maximum length to all
// ones.
`default_nettype none

module resp_command_tokenizer_top #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_token_kind,
  output logic [31:0]      out_token_value,
  output logic             out_count_negative,
  output logic             out_last_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic            s1_valid;
  logic [7:0]      s1_byte;
  logic            out_free;
  logic            step_en;
  logic            res_valid;
  rct_pkg::token_t res;
  rct_pkg::token_t out_token;

  assign cfg_ready = 1'b1;
  assign step_en   = s1_valid && out_free;

  rct_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte_in),
    .advance  (step_en),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  rct_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (step_en),
    .byte_in   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  rct_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_token (out_token)
  );

  assign out_token_kind     = out_token.kind;
  assign out_token_value    = out_token.value;
  assign out_count_negative = out_token.neg;
  assign out_last_byte      = out_token.last;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  // ------------------------------------------------------------------
  // Token predictor and expected-token store
  // ------------------------------------------------------------------
  class token_tracker;
    // register copies
    bit          lower_en;
    logic [31:0] max_len;
    // parser state copy
    rct_pkg::phase_t ph;
    bit          hdr_array;
    logic [31:0] len_acc;
    bit          neg_sign;
    bit          digits_done;
    bit          saw_cr;
    logic [31:0] left;
    logic [1:0]  trailer_cnt;

    rct_pkg::token_t expected_tokens[$];
    int     errors;
    int     kind_seen[4];

    function new();
      lower_en    = 1'b1;
      max_len     = 32'hFFFF_FFFF;
      ph          = rct_pkg::PH_IDLE;
      hdr_array   = 1'b0;
      len_acc     = '0;
      neg_sign    = 1'b0;
      digits_done = 1'b0;
      saw_cr      = 1'b0;
      left        = '0;
      trailer_cnt = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == rct_pkg::CFG_LOWERCASE) begin
        lower_en = data[0];
      end else begin
        max_len = data;
      end
    endfunction

    function void expect_token(rct_pkg::kind_t k, logic [31:0] v, bit n, bit l);
      rct_pkg::token_t t;
      t.kind  = k;
      t.value = v;
      t.neg   = n;
      t.last  = l;
      expected_tokens.push_back(t);
    endfunction

    // decimal accumulate, saturating at all ones
    function void add_digit(logic [7:0] b);
      longint unsigned cap;
      longint unsigned d;
      longint unsigned acc;
      cap = 64'hFFFF_FFFF;
      d   = 64'(b - rct_pkg::CHAR_ZERO);
      acc = 64'(len_acc);
      if (acc > (cap - d) / 10) len_acc = 32'hFFFF_FFFF;
      else len_acc = 32'(acc * 10 + d);
    endfunction

    // atoi-style scan of header text
    function void header_text(logic [7:0] b);
      bit is_digit;
      is_digit = (b >= rct_pkg::CHAR_ZERO) && (b <= rct_pkg::CHAR_NINE);
      if (ph == rct_pkg::PH_LEAD) begin
        if (b == rct_pkg::CHAR_SPACE || (b >= rct_pkg::CHAR_TAB && b <= rct_pkg::CHAR_CR))
          return;
        ph = rct_pkg::PH_NUM;
        if (b == rct_pkg::CHAR_MINUS) neg_sign = 1'b1;
        else if (b == rct_pkg::CHAR_PLUS) neg_sign = neg_sign;
        else if (is_digit) add_digit(b);
        else digits_done = 1'b1;
        return;
      end
      if (!digits_done && is_digit) add_digit(b);
      else digits_done = 1'b1;
    endfunction

    // CR LF seen: close the header
    function void header_end();
      bit n;
      n = neg_sign && (len_acc != 0);
      if (hdr_array) begin
        ph = rct_pkg::PH_IDLE;
        expect_token(rct_pkg::KIND_ARRAY, len_acc, n, 1'b0);
      end else if (n || len_acc > max_len) begin
        ph = rct_pkg::PH_IDLE;
        expect_token(rct_pkg::KIND_ERROR, '0, 1'b0, 1'b0);
      end else if (len_acc == 0) begin
        trailer_cnt = rct_pkg::TRAILER_BYTES;
        ph = rct_pkg::PH_TRAILER;
        expect_token(rct_pkg::KIND_EMPTY, '0, 1'b0, 1'b0);
      end else begin
        left = len_acc;
        ph = rct_pkg::PH_PAYLOAD;
      end
    endfunction

    // one accepted stream byte
    function void accept_byte(logic [7:0] b);
      logic [7:0] v;
      bit is_last;
      case (ph)
        rct_pkg::PH_LEAD, rct_pkg::PH_NUM: begin
          if (b == rct_pkg::CHAR_LF && saw_cr) begin
            header_end();
          end else begin
            saw_cr = (b == rct_pkg::CHAR_CR);
            header_text(b);
          end
        end
        rct_pkg::PH_PAYLOAD: begin
          v = b;
          if (lower_en && b >= rct_pkg::CHAR_UPPER_A && b <= rct_pkg::CHAR_UPPER_Z)
            v = b | rct_pkg::CASE_BIT;
          if (left > 0) left = left - 32'd1;
          is_last = (left == 0);
          if (is_last) begin
            trailer_cnt = rct_pkg::TRAILER_BYTES;
            ph = rct_pkg::PH_TRAILER;
          end
          expect_token(rct_pkg::KIND_BYTE, {24'h0, v}, 1'b0, is_last);
        end
        rct_pkg::PH_TRAILER: begin
          if (trailer_cnt > 0) trailer_cnt = trailer_cnt - 2'd1;
          if (trailer_cnt == 0) ph = rct_pkg::PH_IDLE;
        end
        default: begin
          ph = rct_pkg::PH_IDLE;
          if (b == rct_pkg::CHAR_STAR || b == rct_pkg::CHAR_DOLLAR) begin
            hdr_array   = (b == rct_pkg::CHAR_STAR);
            len_acc     = '0;
            neg_sign    = 1'b0;
            digits_done = 1'b0;
            saw_cr      = 1'b0;
            ph          = rct_pkg::PH_LEAD;
          end else begin
            expect_token(rct_pkg::KIND_ERROR, '0, 1'b0, 1'b0);
          end
        end
      endcase
    endfunction

    // compare one delivered token against the oldest expectation
    function void check_token(logic [1:0] kind, logic [31:0] value, logic n, logic l);
      rct_pkg::token_t t;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token: kind %0d value %h neg %b last %b",
                 $time, kind, value, n, l);
        errors++;
        return;
      end
      t = expected_tokens.pop_front();
      kind_seen[t.kind]++;
      if (t.kind !== kind) begin
        $display("%0t: token_kind expected %0d, got %0d", $time, t.kind, kind);
        errors++;
      end
      if (t.value !== value) begin
        $display("%0t: token_value expected %h, got %h", $time, t.value, value);
        errors++;
      end
      if (t.neg !== n) begin
        $display("%0t: count_negative expected %b, got %b", $time, t.neg, n);
        errors++;
      end
      if (t.last !== l) begin
        $display("%0t: last_byte expected %b, got %b", $time, t.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  // ------------------------------------------------------------------
  // DUT hookup
  // ------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_in;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_token_kind;
  logic [31:0] out_token_value;
  logic        out_count_negative;
  logic        out_last_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  resp_command_tokenizer_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_token_value    (out_token_value),
    .out_count_negative (out_count_negative),
    .out_last_byte      (out_last_byte),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  token_tracker sb;
  logic [7:0]   stream_bytes[$];
  logic [7:0]   num_text[$];
  int           tx_pct = 0;
  int           rx_pct = 0;
  bit           quiet = 1'b0;
  int           n_bytes = 0;
  int           cycles = 0;

  // per-phase register settings and random byte budgets
  bit          lc_set[4]  = '{1'b1, 1'b0, 1'b0, 1'b1};
  logic [31:0] ml_set[4]  = '{32'hFFFF_FFFF, 32'h0, 32'd6, 32'd20};
  int          budget[4]  = '{350, 120, 280, 300};

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < rx_pct);
  end

  // token monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_token(out_token_kind, out_token_value, out_count_negative, out_last_byte);
  end

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------
  // entered and left at a falling edge
  task send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    sb.accept_byte(b);
    n_bytes++;
    @(negedge clk);
  endtask

  task send_stream();
    while (stream_bytes.size() > 0) send_byte(stream_bytes.pop_front());
  endtask

  // both registers in one burst, valid held high between words
  task write_config(input bit lc, input logic [31:0] ml);
    cfg_valid <= 1'b1;
    cfg_index <= rct_pkg::CFG_LOWERCASE;
    cfg_data  <= {31'h0, lc};
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(rct_pkg::CFG_LOWERCASE, {31'h0, lc});
    @(negedge clk);
    cfg_index <= rct_pkg::CFG_MAX_LEN;
    cfg_data  <= ml;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(rct_pkg::CFG_MAX_LEN, ml);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until all tokens are out, then let the pipeline empty
  task settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // ------------------------------------------------------------------
  // Stream builders
  // ------------------------------------------------------------------
  task push_text(input string s);
    for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
  endtask

  task push_crlf();
    stream_bytes.push_back(rct_pkg::CHAR_CR);
    stream_bytes.push_back(rct_pkg::CHAR_LF);
  endtask

  task set_number(input longint unsigned v, input int zeros);
    string s;
    s = $sformatf("%0d", v);
    num_text.delete();
    repeat (zeros) num_text.push_back(rct_pkg::CHAR_ZERO);
    for (int i = 0; i < s.len(); i++) num_text.push_back(s[i]);
  endtask

  task set_long_number();
    int n;
    n = $urandom_range(10, 22);
    num_text.delete();
    num_text.push_back(8'(rct_pkg::CHAR_ZERO + $urandom_range(1, 9)));
    repeat (n - 1) num_text.push_back(8'(rct_pkg::CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  // header: type, optional white space, optional sign, num_text, optional junk, CR LF
  task push_header(input logic [7:0] type_char, input logic [7:0] sign_char);
    logic [7:0] prev;
    logic [7:0] b;
    int n;
    stream_bytes.push_back(type_char);
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(4))
          0: stream_bytes.push_back(rct_pkg::CHAR_SPACE);
          1: stream_bytes.push_back(rct_pkg::CHAR_TAB);
          2: stream_bytes.push_back(rct_pkg::CHAR_LF);
          3: stream_bytes.push_back(8'h0B);
          default: stream_bytes.push_back(8'h0C);
        endcase
      end
    end
    if (sign_char != 8'h00) stream_bytes.push_back(sign_char);
    foreach (num_text[i]) stream_bytes.push_back(num_text[i]);
    // trailing junk only after digits, so it cannot act as a sign
    if (num_text.size() > 0 && $urandom_range(3) == 0) begin
      prev = num_text[num_text.size() - 1];
      n = $urandom_range(1, 4);
      for (int j = 0; j < n; j++) begin
        b = 8'($urandom_range(255));
        if (j == 0 && b >= rct_pkg::CHAR_ZERO && b <= rct_pkg::CHAR_NINE) b = "x";
        if (b == rct_pkg::CHAR_LF && prev == rct_pkg::CHAR_CR) b = "z";
        stream_bytes.push_back(b);
        prev = b;
      end
    end
    push_crlf();
  endtask

  function logic [7:0] pick_sign();
    case ($urandom_range(5))
      0: return rct_pkg::CHAR_MINUS;
      1: return rct_pkg::CHAR_PLUS;
      default: return 8'h00;
    endcase
  endfunction

  task push_trailer();
    stream_bytes.push_back(8'($urandom_range(255)));
    stream_bytes.push_back(8'($urandom_range(255)));
  endtask

  // one random request fragment: mostly well formed, some noise
  task gen_sequence();
    int r;
    int v;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 10) begin
      // bad type byte
      b = 8'($urandom_range(255));
      if (b == rct_pkg::CHAR_STAR || b == rct_pkg::CHAR_DOLLAR) b = ~b;
      stream_bytes.push_back(b);
    end else if (r < 35) begin
      // array header
      r = $urandom_range(99);
      if (r < 70)
        set_number($urandom_range(0, $urandom_range(1) ? 9 : 99999),
                   $urandom_range(0, 2) == 0);
      else if (r < 85) set_long_number();
      else num_text.delete();
      push_header(rct_pkg::CHAR_STAR, pick_sign());
    end else begin
      // bulk string
      r = $urandom_range(99);
      if (r < 10) begin
        set_number($urandom_range(1, 50), 0);
        push_header(rct_pkg::CHAR_DOLLAR, rct_pkg::CHAR_MINUS);
      end else if (r < 15 && sb.max_len < 1000000) begin
        set_long_number();
        push_header(rct_pkg::CHAR_DOLLAR,
                    ($urandom_range(3) == 0) ? rct_pkg::CHAR_PLUS : 8'h00);
      end else begin
        v = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        set_number(v, $urandom_range(0, 3) == 0);
        push_header(rct_pkg::CHAR_DOLLAR,
                    ($urandom_range(4) == 0) ? rct_pkg::CHAR_PLUS : 8'h00);
        if (v <= sb.max_len) begin
          repeat (v) begin
            if ($urandom_range(99) < 35)
              stream_bytes.push_back(8'($urandom_range(rct_pkg::CHAR_UPPER_A,
                                                        rct_pkg::CHAR_UPPER_Z)));
            else
              stream_bytes.push_back(8'($urandom_range(255)));
          end
          push_trailer();
        end
      end
    end
  endtask

  // hand-picked corner cases
  task directed();
    stream_bytes.push_back(8'h00);          // bad type bytes, both extremes
    stream_bytes.push_back(8'hFF);
    push_text("!");
    push_text("*3"); push_crlf();
    push_text("*-1"); push_crlf();
    push_text("*-0"); push_crlf();          // minus zero
    push_text("* \t+42abc"); push_crlf();
    push_text("*1"); stream_bytes.push_back(rct_pkg::CHAR_CR); push_text("2");
    stream_bytes.push_back(rct_pkg::CHAR_LF); push_text("3"); push_crlf();  // lone CR and LF
    push_text("*99999999999"); push_crlf(); // saturation
    push_text("*4294967295"); push_crlf();
    push_text("*"); push_crlf();            // no digits at all
    push_text("$3"); push_crlf(); push_text("AbZ@[");
    push_text("$0"); push_crlf(); push_crlf();
    push_text("$-2"); push_crlf();          // negative bulk length
    push_text("$-0"); push_crlf(); stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    push_text("$1"); push_crlf(); stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'hFF); stream_bytes.push_back(8'h00);
    send_stream();
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    int start;
    sb = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte_in <= 8'h00;
    cfg_valid  <= 1'b0;
    cfg_index  <= rct_pkg::CFG_LOWERCASE;
    cfg_data   <= 32'h0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 4; p++) begin
      // idle pattern: sender light, then receiver light, then none
      case (p)
        0: begin tx_pct = 16; rx_pct = 49; end
        1, 2: begin tx_pct = 49; rx_pct = 16; end
        default: begin tx_pct = 0; rx_pct = 0; end
      endcase
      quiet = 1'b0;
      write_config(lc_set[p], ml_set[p]);
      if (p == 0) directed();
      start = n_bytes;
      while (n_bytes - start < budget[p]) begin
        quiet = ($urandom_range(99) < 15);
        gen_sequence();
        send_stream();
      end
      quiet = 1'b0;
      settle();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected tokens never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("sent %0d bytes over 4 register settings; checked %0d array, %0d payload,",
             n_bytes, sb.kind_seen[rct_pkg::KIND_ARRAY], sb.kind_seen[rct_pkg::KIND_BYTE]);
    $display("%0d empty-string and %0d error tokens; %0d mismatches",
             sb.kind_seen[rct_pkg::KIND_EMPTY], sb.kind_seen[rct_pkg::KIND_ERROR],
             sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rct_pkg.sv
src/rct_in_stage.sv
src/rct_parser.sv
src/rct_out_stage.sv
src/resp_command_tokenizer_top.sv
tb/tb_top.sv
